### rtl/itra_pkg.sv
// Shared types, constants and helper functions for the integer to radix ASCII unit.
package itra_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int IN_VALUE_W      = 32;
    localparam int RADIX_W         = 8;
    localparam int DIGIT_W         = 6;
    localparam int CHAR_W          = 8;

    localparam logic [RADIX_W-1:0] RADIX_MIN  = 8'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX  = 8'd36;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 6'd10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_Z     = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic push;
        logic pop;
    } stack_ctrl_t;

    // Clamp a raw base into 2..36.
    function automatic logic [DIGIT_W-1:0] clamp_radix(input logic [RADIX_W-1:0] raw);
        logic [RADIX_W-1:0] r;
        begin
            r = raw;
            if (raw < RADIX_MIN) begin
                r = RADIX_MIN;
            end else if (raw > RADIX_MAX) begin
                r = RADIX_MAX;
            end
            return r[DIGIT_W-1:0];
        end
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        begin
            if (d < DIGIT_TEN) begin
                c = CHAR_ZERO + CHAR_W'(d);
            end else begin
                c = CHAR_A + CHAR_W'(d - DIGIT_TEN);
            end
            return c;
        end
    endfunction

endpackage

### rtl/itra_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle by a small divisor.
module itra_divider
    import itra_pkg::*;
#(
    parameter int VALUE_W = VALUE_WIDTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [VALUE_W-1:0] dividend,
    input  logic [DIGIT_W-1:0] divisor,
    output logic               done,
    output logic [VALUE_W-1:0] quotient,
    output logic [DIGIT_W-1:0] remainder
);

    localparam int CNT_W = $clog2(VALUE_W);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [VALUE_W-1:0] quo_reg, quo_next;
    logic [DIGIT_W-1:0] rem_reg, rem_next;
    logic [DIGIT_W-1:0] div_reg, div_next;

    logic [DIGIT_W:0]   trial;
    logic [DIGIT_W:0]   diff;
    logic               fits;

    assign trial = {rem_reg, quo_reg[VALUE_W-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign fits  = trial >= {1'b0, div_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(VALUE_W - 1);
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end else if (busy_reg) begin
            // shift in the next dividend bit, subtract when it fits
            rem_next = fits ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
            quo_next = {quo_reg[VALUE_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

### rtl/itra_digit_stack.sv
// Last-in first-out shift stack that reverses the digit order.
module itra_digit_stack
    import itra_pkg::*;
#(
    parameter int DEPTH = VALUE_WIDTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  stack_ctrl_t                ctrl,
    input  logic [DIGIT_W-1:0]         din,
    output logic [DIGIT_W-1:0]         top_digit,
    output logic [$clog2(DEPTH+1)-1:0] depth
);

    localparam int DEPTH_W = $clog2(DEPTH + 1);

    logic [DIGIT_W-1:0] entry_reg [DEPTH];
    logic [DEPTH_W-1:0] depth_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            entry_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++) begin
                entry_reg[i] <= entry_reg[i-1];
            end
        end else if (ctrl.pop) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                entry_reg[i] <= entry_reg[i+1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= '0;
        end else if (ctrl.push) begin
            depth_reg <= depth_reg + 1'b1;
        end else if (ctrl.pop) begin
            depth_reg <= depth_reg - 1'b1;
        end
    end

    assign top_digit = entry_reg[0];
    assign depth     = depth_reg;

endmodule

### rtl/integer_to_radix_ascii_unit.sv
// Flow: the input is loaded, then the serial divider produces each digit in turn, and the
// characters (a leading '-' first for a negative number) go out one per cycle while the sink takes them.
// Throughput: one number at a time; no new number is taken while one is being converted.
// The bit-serial divider sets the rate. Synchronous active-low reset clears the control
// state, the stack depth and the output valid; no clearing pass is needed.
module integer_to_radix_ascii_unit
    import itra_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [39:0]       s_tdata,   // [31:0] value, [39:32] radix
    input  logic [0:0]        s_tuser,   // [0] kind
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [CHAR_W-1:0] m_tdata,   // [7:0] character
    output logic              m_tlast
);

    localparam int DEPTH_W = $clog2(VALUE_WIDTH + 1);

    state_t                 state_reg, state_next;
    logic                   neg_reg, neg_next;
    logic                   out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]      out_char_reg, out_char_next;
    logic                   out_last_reg, out_last_next;

    logic                   out_free;
    logic [VALUE_WIDTH-1:0] in_value;
    logic                   in_neg;
    logic [VALUE_WIDTH-1:0] in_mag;

    logic                   div_start;
    logic [VALUE_WIDTH-1:0] div_dividend;
    logic                   div_done;
    logic [VALUE_WIDTH-1:0] div_quotient;
    logic [DIGIT_W-1:0]     div_remainder;
    logic [DIGIT_W-1:0]     radix_reg, radix_next;

    stack_ctrl_t            stack_ctrl;
    logic [DIGIT_W-1:0]     stack_top;
    logic [DEPTH_W-1:0]     stack_depth;

    assign out_free  = !out_valid_reg || m_tready;
    assign in_value  = VALUE_WIDTH'(s_tdata[IN_VALUE_W-1:0]);
    assign in_neg    = s_tuser[0] && in_value[VALUE_WIDTH-1];
    assign in_mag    = in_neg ? (~in_value + 1'b1) : in_value;

    itra_divider #(
        .VALUE_W (VALUE_WIDTH)
    ) u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (radix_next),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    itra_digit_stack #(
        .DEPTH (VALUE_WIDTH)
    ) u_stack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (stack_ctrl),
        .din       (div_remainder),
        .top_digit (stack_top),
        .depth     (stack_depth)
    );

    always_comb begin
        state_next      = state_reg;
        neg_next        = neg_reg;
        radix_next      = radix_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_char_next   = out_char_reg;
        out_last_next   = out_last_reg;
        div_start       = 1'b0;
        div_dividend    = div_quotient;
        stack_ctrl.push = 1'b0;
        stack_ctrl.pop  = 1'b0;
        s_tready        = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    neg_next     = in_neg;
                    radix_next   = clamp_radix(s_tdata[IN_VALUE_W +: RADIX_W]);
                    div_start    = 1'b1;
                    div_dividend = in_mag;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    stack_ctrl.push = 1'b1;
                    // keep dividing until the quotient runs out
                    if (div_quotient == '0) begin
                        state_next = neg_reg ? ST_SIGN : ST_EMIT;
                    end else begin
                        div_start = 1'b1;
                    end
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_char_next  = CHAR_MINUS;
                    out_last_next  = 1'b0;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_char_next  = digit_char(stack_top);
                    out_last_next  = (stack_depth == DEPTH_W'(1));
                    stack_ctrl.pop = 1'b1;
                    if (stack_depth == DEPTH_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        neg_reg      <= neg_next;
        radix_reg    <= radix_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;

endmodule

### rtl/itra_checker.sv
// Port-level checker for the integer to radix ASCII unit, bound to the top level.
module itra_checker
    import itra_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [CHAR_W-1:0] m_tdata,
    input logic              m_tlast
);

    // hold a stalled character
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output item changed");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted again while a number is in work");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata == CHAR_MINUS)
                  || (m_tdata >= CHAR_ZERO && m_tdata <= CHAR_NINE)
                  || (m_tdata >= CHAR_A && m_tdata <= CHAR_Z))
        else $error("output character outside the digit set");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata == CHAR_MINUS |-> !m_tlast)
        else $error("minus sign marked as last character");

endmodule

bind integer_to_radix_ascii_unit itra_checker u_itra_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
